// File: sv/bitmap_write_claim_table_defines.svh
// Assertion macros shared by the claim table RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BITMAP_WRITE_CLAIM_TABLE_DEFINES_SVH
`define BITMAP_WRITE_CLAIM_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define BWCT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define BWCT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define BWCT_ASSERT(lbl, clk, rst_n, prop)
`define BWCT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/bwct_pkg.sv
// Shared types and codes for the bitmap claim table.
// No dependencies; imported by the interfaces and every module.
`default_nettype none
package bwct_pkg;

	localparam int OPC_W    = 3;
	localparam int BUF_W    = 4;
	localparam int WORD_W   = 6;
	localparam int ELEM_W   = 12;
	localparam int DATA_W   = 64;
	localparam int STATUS_W = 3;
	localparam int KIND_W   = 3;

	// Highest counts the field widths can address
	localparam int FIELD_BUF_LIMIT  = 2 ** BUF_W;
	localparam int FIELD_WORD_LIMIT = 2 ** WORD_W;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef logic [OPC_W-1:0]    opcode_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [KIND_W-1:0]   kind_t;

	// Input opcodes
	localparam opcode_t OPC_STAGE_WORD  = 3'd0;
	localparam opcode_t OPC_STAGE_INDEX = 3'd1;
	localparam opcode_t OPC_CLAIM       = 3'd2;
	localparam opcode_t OPC_RELEASE     = 3'd3;
	localparam opcode_t OPC_READ        = 3'd4;

	// Result status codes
	localparam status_t ST_STAGED   = 3'd0;
	localparam status_t ST_FULL     = 3'd1;
	localparam status_t ST_CLAIMED  = 3'd2;
	localparam status_t ST_CONFLICT = 3'd3;
	localparam status_t ST_RELEASED = 3'd4;
	localparam status_t ST_REJECTED = 3'd5;
	localparam status_t ST_READ     = 3'd6;

	// Command kinds after classification
	localparam kind_t KIND_ACK     = 3'd0;
	localparam kind_t KIND_STAGE   = 3'd1;
	localparam kind_t KIND_CLAIM   = 3'd2;
	localparam kind_t KIND_RELEASE = 3'd3;
	localparam kind_t KIND_READ    = 3'd4;

	typedef struct packed {
		kind_t              kind;
		logic [BUF_W-1:0]   buffer_sel;
		logic               buf_ok;
		logic [WORD_W-1:0]  word;
		logic               word_ok;
		logic [DATA_W-1:0]  mask;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t payload;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef struct packed {
		logic              word_ok;
		logic [WORD_W-1:0] word;
		logic [DATA_W-1:0] mask;
	} stage_entry_t;

endpackage
`default_nettype wire

// File: sv/bwct_ifs.sv
// Channel interfaces: command input and result output, valid/ready handshake.
// Depends on bwct_pkg for field widths.
`default_nettype none
interface bwct_cmd_if import bwct_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPC_W-1:0]    opcode;
	logic [BUF_W-1:0]    buffer_sel;
	logic [WORD_W-1:0]   word_index;
	logic [ELEM_W-1:0]   element_index;
	logic [DATA_W-1:0]   bits;

	modport source(output valid, output opcode, output buffer_sel, output word_index,
		output element_index, output bits, input ready);
	modport sink(input valid, input opcode, input buffer_sel, input word_index,
		input element_index, input bits, output ready);
endinterface

interface bwct_rsp_if import bwct_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   free_bits;

	modport source(output valid, output status, output free_bits, input ready);
	modport sink(input valid, input status, input free_bits, output ready);
endinterface
`default_nettype wire

// File: sv/bitmap_write_claim_table.sv
// Top level of the bitmap claim table: front end, command queue, back end.
// Depends on bwct_pkg, bwct_ifs, bwct_front, bwct_queue and bwct_back.
//
//  channel  modport  payload                                          
//  cmd      sink     opcode, buffer_sel, word_index, element_index, bits
//  rsp      source   status, free_bits
//
// Stage and zero-word commands finish in the back end's idle state; reads of a
// word in range pass through S_RDW. With staged entries and the buffer in range,
// a release commit walks each entry through S_STG, S_MAP and S_MOD and a claim
// walks them up to twice (check, then apply), set by one registered read each of
// staging store and map; rejected, empty or out-of-range commits end in S_IDLE.
// After reset a clearing pass writes zero to every map word, one word a cycle;
// cmd.ready stays low.
// A 2-entry queue lets the front take commands while the back end or rsp stalls.
`default_nettype none
module bitmap_write_claim_table import bwct_pkg::*; #(
	parameter int NUM_BUFFERS      = 16,
	parameter int WORDS_PER_BUFFER = 64,
	parameter int STAGE_DEPTH      = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bwct_cmd_if.sink   cmd,
	bwct_rsp_if.source rsp
);

	push_t       push;
	cmd_t        head;
	queue_stat_t qstat;
	back_stat_t  bstat;
	logic        pop;

	bwct_front #(
		.NUM_BUFFERS     (NUM_BUFFERS),
		.WORDS_PER_BUFFER(WORDS_PER_BUFFER)
	) u_front (
		.cmd  (cmd),
		.qstat(qstat),
		.bstat(bstat),
		.push (push)
	);

	bwct_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.stat  (qstat)
	);

	bwct_back #(
		.NUM_BUFFERS     (NUM_BUFFERS),
		.WORDS_PER_BUFFER(WORDS_PER_BUFFER),
		.STAGE_DEPTH     (STAGE_DEPTH)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.qstat (qstat),
		.pop   (pop),
		.bstat (bstat),
		.rsp   (rsp)
	);

endmodule
`default_nettype wire

// File: sv/bwct_front.sv
// Front end: accepts command transactions, classifies them and pushes the queue.
// Depends on bwct_pkg and bwct_cmd_if.
`default_nettype none
module bwct_front import bwct_pkg::*; #(
	parameter int NUM_BUFFERS      = 16,
	parameter int WORDS_PER_BUFFER = 64
) (
	bwct_cmd_if.sink    cmd,
	input  queue_stat_t qstat,
	input  back_stat_t  bstat,
	output push_t       push
);

	kind_t             kind;
	logic              defined;
	logic [WORD_W-1:0] word_sel;
	logic [DATA_W-1:0] mask_sel;

	// Hold off while the queue is full or the map is being cleared
	assign cmd.ready = !qstat.full && !bstat.clearing;

	// Decode opcode into a command kind, word and bit mask
	always_comb begin
		kind     = KIND_ACK;
		defined  = 1'b1;
		word_sel = cmd.word_index;
		mask_sel = cmd.bits;
		unique case (cmd.opcode)
			OPC_STAGE_WORD: begin
				kind = (cmd.bits == '0) ? KIND_ACK : KIND_STAGE;
			end
			OPC_STAGE_INDEX: begin
				kind     = KIND_STAGE;
				word_sel = cmd.element_index[ELEM_W-1:ELEM_W-WORD_W];
				mask_sel = DATA_W'(1) << cmd.element_index[WORD_W-1:0];
			end
			OPC_CLAIM:   kind = KIND_CLAIM;
			OPC_RELEASE: kind = KIND_RELEASE;
			OPC_READ:    kind = KIND_READ;
			default:     defined = 1'b0;
		endcase
	end

	// Push defined commands; undefined opcodes are taken and dropped
	always_comb begin
		push.valid              = cmd.valid && cmd.ready && defined;
		push.payload.kind       = kind;
		push.payload.buffer_sel = cmd.buffer_sel;
		push.payload.buf_ok     = 32'(cmd.buffer_sel) < 32'(NUM_BUFFERS);
		push.payload.word       = word_sel;
		push.payload.word_ok    = 32'(word_sel) < 32'(WORDS_PER_BUFFER);
		push.payload.mask       = mask_sel;
	end

endmodule
`default_nettype wire

// File: sv/bwct_queue.sv
// Command queue between front and back end, QUEUE_DEPTH entries.
// Depends on bwct_pkg and the assertion macro header.
`default_nettype none
`include "bitmap_write_claim_table_defines.svh"
module bwct_queue import bwct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	input  logic        pop,
	output cmd_t        head,
	output queue_stat_t stat
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push.valid && pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Store pushed command
	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.payload;
		end
	end

	`BWCT_ASSERT(a_no_push_full, clk, arst_n, push.valid |-> !stat.full)
	`BWCT_ASSERT(a_no_pop_empty, clk, arst_n, pop |-> !stat.empty)
	`BWCT_ASSERT(a_cnt_step, clk, arst_n, (push.valid && !pop) |=> cnt_q == $past(cnt_q) + CW'(1))
	`BWCT_ASSERT_ALWAYS(a_cnt_bound, clk, cnt_q <= CW'(QUEUE_DEPTH))

endmodule
`default_nettype wire

// File: sv/bwct_back.sv
// Back end: staging store, claim map memory, commit sequencer and result register.
// Depends on bwct_pkg, bwct_rsp_if and the assertion macro header.
`default_nettype none
`include "bitmap_write_claim_table_defines.svh"
module bwct_back import bwct_pkg::*; #(
	parameter int NUM_BUFFERS      = 16,
	parameter int WORDS_PER_BUFFER = 64,
	parameter int STAGE_DEPTH      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head,
	input  queue_stat_t qstat,
	output logic        pop,
	output back_stat_t  bstat,
	bwct_rsp_if.source  rsp
);

	// Only buffers and words the field widths can reach get storage
	localparam int EFF_BUFFERS = (NUM_BUFFERS < FIELD_BUF_LIMIT) ? NUM_BUFFERS : FIELD_BUF_LIMIT;
	localparam int EFF_WORDS   = (WORDS_PER_BUFFER < FIELD_WORD_LIMIT) ?
		WORDS_PER_BUFFER : FIELD_WORD_LIMIT;
	localparam int MAP_DEPTH   = EFF_BUFFERS * EFF_WORDS;
	localparam int MAP_AW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int SIW         = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
	localparam int SCW         = $clog2(STAGE_DEPTH + 1);
	localparam int AXW         = BUF_W + WORD_W + 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_STG   = 3'd2;
	localparam logic [2:0] S_MAP   = 3'd3;
	localparam logic [2:0] S_MOD   = 3'd4;
	localparam logic [2:0] S_RDW   = 3'd5;

	function automatic logic [MAP_AW-1:0] map_addr(input logic [BUF_W-1:0] b,
			input logic [WORD_W-1:0] w);
		logic [AXW-1:0] a;
		a = AXW'(b) * AXW'(EFF_WORDS) + AXW'(w);
		return a[MAP_AW-1:0];
	endfunction

	logic [2:0]        state_q, state_d;
	logic [MAP_AW-1:0] clr_addr_q, clr_addr_d;
	logic [SCW-1:0]    stg_cnt_q, stg_cnt_d;
	logic              ovf_q, ovf_d;
	logic [SIW-1:0]    idx_q, idx_d;
	logic              pass_apply_q, pass_apply_d;
	logic              claim_q, claim_d;
	logic [BUF_W-1:0]  cur_buf_q, cur_buf_d;

	logic              out_vld_q;
	status_t           out_status_q;
	logic [DATA_W-1:0] out_free_q;

	stage_entry_t      stg_mem [STAGE_DEPTH];
	stage_entry_t      stg_rd_q;
	logic              stg_we;

	logic [DATA_W-1:0] map_mem [MAP_DEPTH];
	logic [DATA_W-1:0] map_rd_q;
	logic              map_we;
	logic [MAP_AW-1:0] map_waddr;
	logic [MAP_AW-1:0] map_raddr;
	logic [DATA_W-1:0] map_wdata;
	logic [MAP_AW-1:0] entry_addr;

	logic              slot_free;
	logic              start;
	logic              last_entry;
	logic              conflict;
	logic              res_load;
	status_t           res_status;
	logic [DATA_W-1:0] res_free;

	assign slot_free      = !out_vld_q || rsp.ready;
	assign start          = (state_q == S_IDLE) && !qstat.empty && slot_free;
	assign pop            = start;
	assign bstat.clearing = (state_q == S_CLEAR);
	assign entry_addr     = map_addr(cur_buf_q, stg_rd_q.word);
	assign last_entry     = (SCW'(idx_q) + SCW'(1) == stg_cnt_q);
	assign conflict       = stg_rd_q.word_ok && !pass_apply_q &&
		((map_rd_q & stg_rd_q.mask) != '0);

	// Sequence clearing, staging, commits and reads
	always_comb begin
		state_d      = state_q;
		clr_addr_d   = clr_addr_q;
		stg_cnt_d    = stg_cnt_q;
		ovf_d        = ovf_q;
		idx_d        = idx_q;
		pass_apply_d = pass_apply_q;
		claim_d      = claim_q;
		cur_buf_d    = cur_buf_q;
		stg_we       = 1'b0;
		map_we       = 1'b0;
		map_waddr    = clr_addr_q;
		map_wdata    = '0;
		map_raddr    = map_addr(head.buffer_sel, head.word);
		res_load     = 1'b0;
		res_status   = ST_STAGED;
		res_free     = '0;
		unique case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
				if (clr_addr_q == MAP_AW'(MAP_DEPTH - 1)) begin
					state_d = S_IDLE;
				end else begin
					clr_addr_d = clr_addr_q + MAP_AW'(1);
				end
			end
			S_IDLE: begin
				if (start) begin
					unique case (head.kind) inside
						KIND_ACK: begin
							res_load = 1'b1;
						end
						KIND_STAGE: begin
							res_load = 1'b1;
							if (stg_cnt_q == SCW'(STAGE_DEPTH)) begin
								ovf_d      = 1'b1;
								res_status = ST_FULL;
							end else begin
								stg_we    = 1'b1;
								stg_cnt_d = stg_cnt_q + SCW'(1);
							end
						end
						KIND_CLAIM, KIND_RELEASE: begin
							claim_d   = (head.kind == KIND_CLAIM);
							cur_buf_d = head.buffer_sel;
							if (ovf_q) begin
								res_load   = 1'b1;
								res_status = ST_REJECTED;
								stg_cnt_d  = '0;
								ovf_d      = 1'b0;
							end else if (!head.buf_ok || stg_cnt_q == '0) begin
								res_load   = 1'b1;
								res_status = (head.kind == KIND_CLAIM) ? ST_CLAIMED : ST_RELEASED;
								stg_cnt_d  = '0;
							end else begin
								idx_d        = '0;
								pass_apply_d = (head.kind == KIND_RELEASE);
								state_d      = S_STG;
							end
						end
						KIND_READ: begin
							if (head.buf_ok && head.word_ok) begin
								state_d = S_RDW;
							end else begin
								res_load   = 1'b1;
								res_status = ST_READ;
							end
						end
						default: begin
							res_load = 1'b0;
						end
					endcase
				end
			end
			S_STG: begin
				state_d = S_MAP;
			end
			S_MAP: begin
				map_raddr = entry_addr;
				state_d   = S_MOD;
			end
			S_MOD: begin
				map_waddr = entry_addr;
				map_wdata = claim_q ? (map_rd_q | stg_rd_q.mask) : (map_rd_q & ~stg_rd_q.mask);
				map_we    = pass_apply_q && stg_rd_q.word_ok;
				if (conflict) begin
					res_load   = 1'b1;
					res_status = ST_CONFLICT;
					stg_cnt_d  = '0;
					state_d    = S_IDLE;
				end else if (!last_entry) begin
					idx_d   = idx_q + SIW'(1);
					state_d = S_STG;
				end else if (!pass_apply_q) begin
					pass_apply_d = 1'b1;
					idx_d        = '0;
					state_d      = S_STG;
				end else begin
					res_load   = 1'b1;
					res_status = claim_q ? ST_CLAIMED : ST_RELEASED;
					stg_cnt_d  = '0;
					state_d    = S_IDLE;
				end
			end
			S_RDW: begin
				res_load   = 1'b1;
				res_status = ST_READ;
				res_free   = ~map_rd_q;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			stg_cnt_q    <= '0;
			ovf_q        <= 1'b0;
			idx_q        <= '0;
			pass_apply_q <= 1'b0;
			claim_q      <= 1'b0;
			cur_buf_q    <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			clr_addr_q   <= clr_addr_d;
			stg_cnt_q    <= stg_cnt_d;
			ovf_q        <= ovf_d;
			idx_q        <= idx_d;
			pass_apply_q <= pass_apply_d;
			claim_q      <= claim_d;
			cur_buf_q    <= cur_buf_d;
			if (res_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_status_q <= res_status;
			out_free_q   <= res_free;
		end
	end

	// Staging store: write at fill count, registered read at walk index
	always_ff @(posedge clk) begin
		if (stg_we) begin
			stg_mem[stg_cnt_q[SIW-1:0]] <= '{word_ok: head.word_ok, word: head.word,
				mask: head.mask};
		end
		stg_rd_q <= stg_mem[idx_q];
	end

	// Claim map memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rd_q <= map_mem[map_raddr];
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.status    = out_status_q;
	assign rsp.free_bits = out_free_q;

	`BWCT_ASSERT_ALWAYS(a_no_pop_clear, clk, (state_q == S_CLEAR) |-> !pop)
	`BWCT_ASSERT(a_slot_free, clk, arst_n, res_load |-> slot_free)
	`BWCT_ASSERT(a_map_we_src, clk, arst_n,
		map_we |-> (state_q == S_CLEAR) || (state_q == S_MOD && pass_apply_q))
	`BWCT_ASSERT(a_commit_empties, clk, arst_n,
		(res_load && (res_status == ST_CLAIMED || res_status == ST_CONFLICT || res_status == ST_RELEASED || res_status == ST_REJECTED)) |=> (stg_cnt_q == '0 && !ovf_q))

endmodule
`default_nettype wire
